// ===== design/mpi_pkg.sv =====
package mpi_pkg;

  // Fixed prime modulus and the values derived from it.
  localparam int unsigned   MOD_BITS   = 30;
  localparam logic [29:0]   MODULUS    = 30'd1000000007;
  localparam logic [29:0]   INV_EXP    = 30'd1000000005;
  localparam int unsigned   INV_BITS   = 30;

  // Barrett constant floor(2^60 / MODULUS).
  localparam logic [30:0]   BARRETT_MU = 31'd1152921496;

  localparam logic [31:0]   MOD_X1     = 32'd1000000007;
  localparam logic [31:0]   MOD_X2     = 32'd2000000014;

  // Operation codes carried on in_cmd.
  localparam logic          CMD_POWER  = 1'b0;
  localparam logic          CMD_INV    = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_MU_GO,
    ST_MU_WAIT,
    ST_DONE
  } mpi_state_t;

  typedef enum logic [2:0] {
    MM_IDLE,
    MM_PROD,
    MM_QUOT,
    MM_QMUL,
    MM_SUB,
    MM_RED
  } mpi_mm_state_t;

  typedef struct packed {
    logic                valid;
    logic [MOD_BITS-1:0] a;
    logic [MOD_BITS-1:0] b;
  } mpi_mm_req_t;

  typedef struct packed {
    logic                done;
    logic [MOD_BITS-1:0] value;
  } mpi_mm_rsp_t;

endpackage

// ===== design/mpi_mulmod.sv =====
module mpi_mulmod (
  input  logic                clk,
  input  logic                rst_n,
  input  mpi_pkg::mpi_mm_req_t req,
  output mpi_pkg::mpi_mm_rsp_t rsp
);
  import mpi_pkg::*;

  // One 32x32 multiplier is shared by the product and both Barrett steps.
  mpi_mm_state_t state_r, state_nxt;
  logic [29:0] a_r;
  logic [29:0] b_r;
  logic [63:0] prod_r;
  logic [31:0] p_r;
  logic [31:0] rem_r;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;
  logic [31:0] red_val;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      MM_IDLE: if (req.valid) state_nxt = MM_PROD;
      MM_PROD: state_nxt = MM_QUOT;
      MM_QUOT: state_nxt = MM_QMUL;
      MM_QMUL: state_nxt = MM_SUB;
      MM_SUB:  state_nxt = MM_RED;
      MM_RED:  state_nxt = MM_IDLE;
      default: state_nxt = MM_IDLE;
    endcase
  end

  always_comb begin
    case (state_r)
      MM_QUOT: begin
        mul_a = {1'b0, prod_r[59:29]};
        mul_b = {1'b0, BARRETT_MU};
      end
      MM_QMUL: begin
        mul_a = {1'b0, prod_r[61:31]};
        mul_b = MOD_X1;
      end
      default: begin
        mul_a = {2'b00, a_r};
        mul_b = {2'b00, b_r};
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // The remainder is below three times the modulus.
  always_comb begin
    if (rem_r >= MOD_X2) begin
      red_val = rem_r - MOD_X2;
    end else if (rem_r >= MOD_X1) begin
      red_val = rem_r - MOD_X1;
    end else begin
      red_val = rem_r;
    end
  end

  always_comb begin
    rsp.done  = (state_r == MM_RED);
    rsp.value = red_val[29:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == MM_IDLE && req.valid) begin
      a_r <= req.a;
      b_r <= req.b;
    end
    if (state_r == MM_PROD || state_r == MM_QUOT || state_r == MM_QMUL) begin
      prod_r <= mul_p;
    end
    if (state_r == MM_QUOT) begin
      p_r <= prod_r[31:0];
    end
    if (state_r == MM_SUB) begin
      rem_r <= p_r - prod_r[31:0];
    end
  end

endmodule

// ===== design/modular_power_and_inverse_top.sv =====
// Channel    | Ports                                  | Handshake
// -----------+----------------------------------------+-----------------------------------
// input      | in_cmd, in_base, in_exponent           | start high while busy is low
// result     | out_result                             | out_valid strobe, one cycle
//
// Each transaction runs one square-and-multiply step per exponent bit, most
// significant bit first: EXP_BITS steps for a power, 30 steps for an inverse.
// Every square and every multiply by the base runs on the shared multiplier.
// Reset (synchronous, active low) returns the sequencer to idle; no clearing.
// The receiver cannot stall: out_valid is high for exactly one cycle.
module modular_power_and_inverse_top #(
  parameter int EXP_BITS = 63
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_cmd,
  input  logic [29:0] in_base,
  input  logic [62:0] in_exponent,
  output logic        out_valid,
  output logic [29:0] out_result
);
  import mpi_pkg::*;

  // The exponent register is wide enough for either command; the bit under
  // work is always its top bit, and it shifts left once per step.
  localparam int EW    = (EXP_BITS > INV_BITS) ? EXP_BITS : INV_BITS;
  localparam int CNT_W = $clog2(EW + 1);

  mpi_state_t     state_r, state_nxt;
  logic [29:0]    base_r, base_nxt;
  logic [29:0]    acc_r, acc_nxt;
  logic [EW-1:0]  exp_r, exp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic           accept;
  logic           last_bit;
  mpi_mm_req_t    mm_req;
  mpi_mm_rsp_t    mm_rsp;

  mpi_mulmod u_mulmod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .rsp   (mm_rsp)
  );

  assign accept   = start && !busy;
  assign last_bit = (cnt_r == CNT_W'(1));

  // Next state. A bit finishes after its square when it is clear, or after
  // the multiply by the base when it is set.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (start) state_nxt = ST_SQ_GO;
      ST_SQ_GO: state_nxt = ST_SQ_WAIT;
      ST_SQ_WAIT: begin
        if (mm_rsp.done) begin
          if (exp_r[EW-1]) begin
            state_nxt = ST_MU_GO;
          end else if (last_bit) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_SQ_GO;
          end
        end
      end
      ST_MU_GO: state_nxt = ST_MU_WAIT;
      ST_MU_WAIT: begin
        if (mm_rsp.done) begin
          state_nxt = last_bit ? ST_DONE : ST_SQ_GO;
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    busy         = (state_r != ST_IDLE);
    out_valid    = (state_r == ST_DONE);
    out_result   = acc_r;
    mm_req.valid = (state_r == ST_SQ_GO) || (state_r == ST_MU_GO);
    mm_req.a     = acc_r;
    mm_req.b     = (state_r == ST_MU_GO) ? base_r : acc_r;
  end

  // Datapath next values.
  always_comb begin
    base_nxt = base_r;
    acc_nxt  = acc_r;
    exp_nxt  = exp_r;
    cnt_nxt  = cnt_r;
    if (accept) begin
      // One conditional subtraction brings any 30-bit base below the modulus.
      base_nxt = (in_base >= MODULUS) ? (in_base - MODULUS) : in_base;
      acc_nxt  = 30'd1;
      if (in_cmd == CMD_INV) begin
        exp_nxt = EW'(INV_EXP) << (EW - INV_BITS);
        cnt_nxt = CNT_W'(INV_BITS);
      end else begin
        exp_nxt = EW'(in_exponent[EXP_BITS-1:0]) << (EW - EXP_BITS);
        cnt_nxt = CNT_W'(EXP_BITS);
      end
    end else if (mm_rsp.done) begin
      acc_nxt = mm_rsp.value;
      if (state_r == ST_MU_WAIT || !exp_r[EW-1]) begin
        exp_nxt = exp_r << 1;
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    acc_r  <= acc_nxt;
    exp_r  <= exp_nxt;
    cnt_r  <= cnt_nxt;
  end

  // A result strobe lasts a single cycle and is never followed directly by
  // another one.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // Every result is fully reduced.
  a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result < MODULUS))
    else $error("result not below the modulus");

  // An accepted transaction keeps the block busy on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting a transaction");

  // The multiply unit only answers while the sequencer waits for it.
  a_rsp_expected: assert property (@(posedge clk) disable iff (!rst_n)
    mm_rsp.done |-> (state_r == ST_SQ_WAIT || state_r == ST_MU_WAIT))
    else $error("unexpected response from the multiply unit");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the modular power / modular inverse block.
// A queue of pending operations is filled once at time zero: a short directed
// list first, then a long random tail. A clocked driver presents them one
// transaction at a time on the start/busy handshake. A clocked monitor
// predicts the residue of every accepted transaction and compares it with the
// strobed result.
module tb;
  import mpi_pkg::*;

  localparam int EXP_BITS = 63;

  // The bench keeps its own copy of the prime and of the Fermat exponent, so
  // that a wrong constant in the design package cannot hide itself.
  localparam logic [63:0] PRIME      = 64'd1000000007;
  localparam logic [62:0] FERMAT_EXP = 63'd1000000005;

  // LONGEST_OP is the cost of the slowest transaction, every exponent bit set. The
  // watchdog allows several times that plus the longest sender gap.
  localparam int LONGEST_OP  = 12 * EXP_BITS + 2;
  localparam int STALL_LIMIT = 5 * (LONGEST_OP + 16);
  localparam int RANDOM_OPS  = 1380;

  typedef struct {
    logic        cmd;
    logic [29:0] base;
    logic [62:0] exponent;
    int          gap;    // Idle cycles in front of this transaction.
    bit          drain;  // Wait for every outstanding result before sending.
  } pow_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_cmd = CMD_POWER;
  logic [29:0] in_base = '0;
  logic [62:0] in_exponent = '0;
  logic        out_valid;
  logic [29:0] out_result;

  pow_req_t    pending_ops[$];
  logic [29:0] expected_residues[$];

  // These counters, all but total_ops, are only written with nonblocking assignments, so
  // every other process reads a value that is stable for the whole clock edge.
  int outstanding  = 0;
  int accepted_cnt = 0;
  int stall_cycles = 0;
  int failures     = 0;
  int gap_cnt      = 0;
  int total_ops;

  modular_power_and_inverse_top #(
    .EXP_BITS(EXP_BITS)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_cmd     (in_cmd),
    .in_base    (in_base),
    .in_exponent(in_exponent),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  always #2 clk = ~clk;

  // Left-to-right square-and-multiply over the low nbits of the exponent.
  // Both operands stay below the prime, so every product fits in 60 bits.
  function automatic logic [29:0] mod_exp(input logic [63:0] b, input logic [62:0] e,
                                          input int nbits);
    logic [63:0] acc;
    acc = 64'd1;
    for (int i = nbits - 1; i >= 0; i--) begin
      acc = (acc * acc) % PRIME;
      if (e[i]) begin
        acc = (acc * b) % PRIME;
      end
    end
    return acc[29:0];
  endfunction

  // A base at or above the prime is folded back with one subtraction, which is
  // enough for any 30-bit value. The inverse ignores the exponent port.
  function automatic logic [29:0] predict_residue(input logic cmd, input logic [29:0] base,
                                                  input logic [62:0] exponent);
    logic [63:0] b;
    b = {34'd0, base};
    if (b >= PRIME) begin
      b = b - PRIME;
    end
    if (cmd == CMD_INV) begin
      return mod_exp(b, FERMAT_EXP, 30);
    end else begin
      return mod_exp(b, exponent, EXP_BITS);
    end
  endfunction

  function automatic void add_op(input logic cmd, input logic [29:0] base,
                                 input logic [62:0] exponent, input int gap, input bit drain);
    pow_req_t op;
    op.cmd      = cmd;
    op.base     = base;
    op.exponent = exponent;
    op.gap      = gap;
    op.drain    = drain;
    pending_ops = {pending_ops, op};
  endfunction

  // Driver. While a transaction is offered and the block is busy, the inputs
  // hold. Otherwise the driver either idles out the gap of the next queued
  // transaction, waits for the pipeline to empty when that transaction asks
  // for a drain, or puts it on the ports. Each input gets one assignment per
  // edge, so a back-to-back transaction keeps start high without a glitch.
  always @(posedge clk) begin
    pow_req_t op;
    if (!rst_n) begin
      start   <= 1'b0;
      gap_cnt <= 0;
    end else if (!(start && busy)) begin
      if (pending_ops.size() == 0) begin
        start <= 1'b0;
      end else if (gap_cnt < pending_ops[0].gap) begin
        start   <= 1'b0;
        gap_cnt <= gap_cnt + 1;
      end else if (pending_ops[0].drain && (start || outstanding != 0)) begin
        // A transaction taken at this very edge is not yet counted in
        // outstanding, hence the extra check on start.
        start <= 1'b0;
      end else begin
        op          = pending_ops.pop_front();
        start       <= 1'b1;
        in_cmd      <= op.cmd;
        in_base     <= op.base;
        in_exponent <= op.exponent;
        gap_cnt     <= 0;
      end
    end
  end

  // Monitor. Results are checked first, and the prediction for a transaction
  // taken at the same edge is queued afterwards, so the order of the two
  // never depends on the scheduler. Input ports are read before the driver's
  // nonblocking updates land, which gives the values the block sampled.
  always @(posedge clk) begin
    int          errs;
    logic        took;
    logic [29:0] want;
    errs = 0;
    took = rst_n && start && !busy;
    if (rst_n && out_valid) begin
      if (expected_residues.size() == 0) begin
        $error("out_result %0d arrived with no transaction outstanding", out_result);
        errs++;
      end else begin
        want = expected_residues.pop_front();
        if (out_result !== want) begin
          $error("out_result mismatch: expected %0d, actual %0d", want, out_result);
          errs++;
        end
      end
    end
    if (took) begin
      expected_residues = {expected_residues, predict_residue(in_cmd, in_base, in_exponent)};
    end
    outstanding  <= expected_residues.size();
    accepted_cnt <= accepted_cnt + (took ? 1 : 0);
    failures     <= failures + errs;
    stall_cycles <= (took || (rst_n && out_valid)) ? 0 : stall_cycles + 1;
  end

  initial begin
    logic        cmd;
    logic [29:0] base;
    logic [62:0] exponent;
    int          gap;

    // Directed part: the corners of every field and each special case.
    // Zero exponent gives one, even for a zero base.
    add_op(CMD_POWER, 30'd0, 63'd0, 0, 1'b0);
    add_op(CMD_POWER, 30'd5, 63'd0, 0, 1'b0);
    // An exponent of one returns the base itself.
    add_op(CMD_POWER, 30'd12345, 63'd1, 0, 1'b0);
    add_op(CMD_POWER, 30'd1000000006, 63'd1, 0, 1'b0);
    add_op(CMD_POWER, 30'd1000000006, 63'd2, 3, 1'b0);
    add_op(CMD_POWER, 30'd0, 63'd5, 0, 1'b0);
    add_op(CMD_POWER, 30'd2, 63'd10, 0, 1'b0);
    add_op(CMD_POWER, 30'd2, 63'd1 << 62, 0, 1'b0);
    add_op(CMD_POWER, 30'd3, {63{1'b1}}, 0, 1'b0);
    add_op(CMD_POWER, 30'd1000000006, {63{1'b1}}, 7, 1'b0);
    // Bases at or above the prime are folded back before use.
    add_op(CMD_POWER, 30'h3FFFFFFF, 63'd1, 0, 1'b0);
    add_op(CMD_POWER, 30'd1000000007, 63'd1, 0, 1'b0);
    add_op(CMD_POWER, 30'd1000000007, 63'd0, 0, 1'b0);
    add_op(CMD_POWER, 30'h3FFFFFFF, {63{1'b1}}, 0, 1'b1);
    // Inverse of zero is zero; the exponent port is ignored for inverses.
    add_op(CMD_INV, 30'd0, 63'd0, 0, 1'b0);
    add_op(CMD_INV, 30'd1, 63'd0, 0, 1'b0);
    add_op(CMD_INV, 30'd2, {63{1'b1}}, 0, 1'b0);
    add_op(CMD_INV, 30'd1000000006, 63'd0, 2, 1'b0);
    add_op(CMD_INV, 30'h3FFFFFFF, 63'h5555_5555_5555_5555, 0, 1'b0);
    add_op(CMD_INV, 30'd1000000007, 63'd0, 0, 1'b0);
    // Raising to the prime minus two must agree with the inverse command.
    add_op(CMD_POWER, 30'd987654321, 63'd1000000005, 0, 1'b0);
    add_op(CMD_INV, 30'd987654321, 63'd0, 0, 1'b1);

    // Random part. Every fourth stretch runs with no idle cycles at all, and
    // now and then the sender holds off until every result has come back.
    for (int i = 0; i < RANDOM_OPS; i++) begin
      cmd = ($urandom_range(0, 3) == 0) ? CMD_INV : CMD_POWER;
      case ($urandom_range(0, 9))
        0: begin
          case ($urandom_range(0, 2))
            0: base = 30'd0;
            1: base = 30'd1;
            default: base = 30'd1000000006;
          endcase
        end
        1: base = 30'($urandom_range(1000000007, 32'h3FFFFFFF));
        default: base = 30'($urandom_range(0, 1000000006));
      endcase
      case ($urandom_range(0, 7))
        0: exponent = 63'($urandom_range(0, 3));
        1: exponent = 63'd1 << $urandom_range(0, 62);
        2: exponent = {63{1'b1}} ^ (63'd1 << $urandom_range(0, 62));
        3: exponent = FERMAT_EXP;
        default: exponent = 63'({$urandom(), $urandom()});
      endcase
      gap = (((i / 120) % 4) == 0) ? 0 : $urandom_range(0, 15);
      add_op(cmd, base, exponent, gap, (i % 175) == 174);
    end
    total_ops = pending_ops.size();

    // Synchronous reset, held from time zero and never asserted again.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every transaction has been taken and every result checked,
    // or until the watchdog sees the block stuck.
    while (stall_cycles < STALL_LIMIT && !(accepted_cnt == total_ops && outstanding == 0)) begin
      @(posedge clk);
    end

    if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
    end else begin
      // Give a stray extra result one full transaction time to show up.
      repeat (LONGEST_OP + 16) @(posedge clk);
      if (failures == 0 && outstanding == 0) begin
        $display("[ OK ] regression clean");
      end else begin
        $display("[FAIL] regression broken");
      end
    end
    $finish;
  end

endmodule
